// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker modules of the RTL folder.
// Needs a clk and an active-high synchronous rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define BSC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bsc_pkg.sv -----
// Shared types, constants and helpers of the barometric sensor compensation.
// No dependencies.
package bsc_pkg;

  localparam int InWidth = 32;
  localparam int OutWidth = 72;

  localparam int B6Offset = 4000;
  localparam int X3Offset = 32768;
  localparam int PressScale = 50000;
  localparam int PressC1 = 3038;
  localparam int PressC2 = 7357;
  localparam int PressC3 = 3791;
  localparam int TempRound = 8;

  typedef enum logic [1:0] {
    CfgTempCoeffs   = 2'd0,
    CfgPressCoeffsA = 2'd1,
    CfgPressCoeffsB = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] raw_pressure;
    logic [15:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic               divide_error;
    logic signed [31:0] pressure_pa;
    logic signed [31:0] temperature_tenths;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    logic signed [31:0] r;
    if (v > 63'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -63'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bsc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Carries a valid bit and a sideband word along; stalls on a shared enable.
module bsc_div #(
  parameter int NumWidth = 27,
  parameter int DenWidth = 20,
  parameter int SideWidth = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NumWidth-1:0]  in_num,
  input  logic [DenWidth-1:0]  in_den,
  input  logic [SideWidth-1:0] in_side,
  output logic                 out_valid,
  output logic [NumWidth-1:0]  out_quo,
  output logic [SideWidth-1:0] out_side
);

  logic                 v_q    [NumWidth];
  logic [DenWidth-1:0]  rem_q  [NumWidth];
  logic [NumWidth-1:0]  quo_q  [NumWidth];
  logic [DenWidth-1:0]  den_q  [NumWidth];
  logic [SideWidth-1:0] side_q [NumWidth];

  for (genvar k = 0; k < NumWidth; k++) begin : g_stage
    logic                 v_i;
    logic [DenWidth-1:0]  rem_i;
    logic [NumWidth-1:0]  quo_i;
    logic [DenWidth-1:0]  den_i;
    logic [SideWidth-1:0] side_i;
    logic [DenWidth:0]    trial;
    logic [DenWidth:0]    diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign quo_i  = in_num;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign den_i  = den_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign trial = {rem_i, quo_i[NumWidth-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
        quo_q[k]  <= {quo_i[NumWidth-2:0], ge};
        den_q[k]  <= den_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = v_q[NumWidth-1];
  assign out_quo   = quo_q[NumWidth-1];
  assign out_side  = side_q[NumWidth-1];

endmodule

// ----- hw/rtl/barometric_sensor_compensation.sv -----
// Barometric sensor compensation, top level. Uses bsc_pkg and bsc_div.
// Throughput: one item per cycle while the output is not stalled. The two
// quotient pipelines in series (27 and 61 stages) hold most of the stages.
// Reset clears all valid bits, the skid valid flag and the calibration
// registers; the whole pipeline stalls while an output transfer waits.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_temperature[15:0], raw_pressure[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // temperature_tenths[31:0], pressure_pa[63:32],
                                 // divide_error[64], zero[71:65]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // calibration
  logic [63:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [31:0] press_coeffs_b;

  logic [15:0]        ac5, ac6, ac4;
  logic signed [15:0] mc, md, ac1, ac2, ac3, b1, b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::CfgTempCoeffs:   temp_coeffs    <= cfg_data;
        bsc_pkg::CfgPressCoeffsA: press_coeffs_a <= cfg_data;
        bsc_pkg::CfgPressCoeffsB: press_coeffs_b <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign ac5 = temp_coeffs[63:48];
  assign ac6 = temp_coeffs[47:32];
  assign mc  = temp_coeffs[31:16];
  assign md  = temp_coeffs[15:0];
  assign ac1 = press_coeffs_a[63:48];
  assign ac2 = press_coeffs_a[47:32];
  assign ac3 = press_coeffs_a[31:16];
  assign ac4 = press_coeffs_a[15:0];
  assign b1  = press_coeffs_b[31:16];
  assign b2  = press_coeffs_b[15:0];

  // handshake and skid
  logic               en;
  logic               s_accept;
  logic               skid_valid;
  bsc_pkg::in_item_t  skid_data;
  bsc_pkg::in_item_t  in_item;
  bsc_pkg::out_item_t out_data;
  logic               out_v;

  assign en       = !out_v || m_tready;
  assign s_tready = !skid_valid;
  assign s_accept = s_tvalid && s_tready;
  assign in_item  = skid_valid ? skid_data : bsc_pkg::in_item_t'(s_tdata);
  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && !en) begin
      skid_data <= bsc_pkg::in_item_t'(s_tdata);
    end
  end

  // stage registers
  logic s0_v, s1_v, s2_v;
  logic p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v, p8_v;
  logic q1_v, q2_v, q3_v, q4_v, q5_v;

  logic [15:0]        s0_ut, s0_up, s1_up, s2_up;
  logic signed [33:0] s1_prod;
  logic signed [18:0] s2_t_x1, s2_x1;
  logic signed [19:0] s2_t_den, s2_den;

  logic signed [29:0] p1_t_sum;
  logic signed [27:0] p1_b6;
  logic signed [25:0] p2_t_val, p3_t_val, p4_t_val, p5_t_val, p6_t_val, p7_t_val, p8_t_val;
  logic [15:0]        p1_up, p2_up, p3_up, p4_up, p5_up;
  logic               p1_err, p2_err, p3_err, p4_err, p5_err, p6_err, p7_err, p8_err;
  logic signed [55:0] p2_b6sq;
  logic signed [43:0] p2_ac2b6, p2_ac3b6;
  logic signed [58:0] p3_b2sq, p3_b1sq;
  logic signed [32:0] p3_x2a;
  logic signed [30:0] p3_x1c;
  logic signed [49:0] p4_b3num;
  logic signed [43:0] p4_x3bnum;
  logic signed [47:0] p5_b3;
  logic signed [42:0] p5_s;
  logic signed [48:0] p6_upb3;
  logic signed [59:0] p6_b4p;
  logic signed [60:0] p7_b7;
  logic signed [44:0] p7_b4;
  logic [60:0]        p8_n_abs;
  logic [44:0]        p8_b4_abs;
  logic               p8_neg, p8_case1;

  logic signed [61:0] q1_q;
  logic signed [25:0] q1_t_val, q2_t_val, q3_t_val, q4_t_val, q5_t_val;
  logic               q1_err, q2_err, q3_err, q4_err, q5_err, q1_case1;
  logic signed [31:0] q2_p, q3_p, q4_p, q5_p;
  logic signed [47:0] q3_x1sq;
  logic signed [46:0] q3_m2;
  logic [42:0]        q4_yf;
  logic signed [30:0] q4_x2;
  logic signed [44:0] q5_c;

  // temperature quotient stage inputs
  logic signed [16:0] ut_diff;
  logic signed [33:0] prod_rnd;
  logic signed [18:0] t_x1_c, x1_c;
  logic [15:0]        mc_abs;
  logic [26:0]        mc_num;
  logic [19:0]        t_den_abs, den_abs;
  logic               t_err;

  assign ut_diff   = $signed({1'b0, s0_ut}) - $signed({1'b0, ac6});
  assign prod_rnd  = s1_prod + (s1_prod[33] ? 34'sd32767 : 34'sd0);
  assign t_x1_c    = prod_rnd[33:15];
  assign x1_c      = s1_prod[33:15];
  assign mc_abs    = mc[15] ? 16'(-mc) : 16'(mc);
  assign mc_num    = {mc_abs, 11'd0};
  assign t_den_abs = s2_t_den[19] ? 20'(-s2_t_den) : 20'(s2_t_den);
  assign den_abs   = s2_den[19] ? 20'(-s2_den) : 20'(s2_den);
  assign t_err     = (s2_t_den == '0) || (s2_den == '0);

  logic               da_v, db_v, d_v;
  logic [26:0]        da_quo, db_quo;
  logic [55:0]        da_side;
  logic [0:0]         db_side;
  logic signed [18:0] a_t_x1, a_x1;
  logic [15:0]        a_up;
  logic               a_err, a_neg;
  logic signed [27:0] q_t, q_p;

  bsc_div #(
    .NumWidth (27),
    .DenWidth (20),
    .SideWidth(56)
  ) u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_v),
    .in_num   (mc_num),
    .in_den   (t_den_abs),
    .in_side  ({s2_t_x1, s2_x1, s2_up, t_err, mc[15] ^ s2_t_den[19]}),
    .out_valid(da_v),
    .out_quo  (da_quo),
    .out_side (da_side)
  );

  bsc_div #(
    .NumWidth (27),
    .DenWidth (20),
    .SideWidth(1)
  ) u_div_b5 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_v),
    .in_num   (mc_num),
    .in_den   (den_abs),
    .in_side  (mc[15] ^ s2_den[19]),
    .out_valid(db_v),
    .out_quo  (db_quo),
    .out_side (db_side)
  );

  assign {a_t_x1, a_x1, a_up, a_err, a_neg} = da_side;
  assign d_v = da_v & db_v;
  assign q_t = a_neg ? -$signed({1'b0, da_quo}) : $signed({1'b0, da_quo});
  assign q_p = db_side[0] ? -$signed({1'b0, db_quo}) : $signed({1'b0, db_quo});

  // pressure chain helpers
  logic signed [28:0] b6_w;
  logic signed [29:0] t_rnd;
  logic [41:0]        sq;
  logic signed [47:0] x1p;
  logic signed [42:0] x2b;
  logic signed [49:0] b3_rnd;
  logic signed [43:0] x3_rnd;
  logic signed [41:0] x3b;
  logic signed [65:0] b7_w;
  logic               case1;
  logic signed [60:0] n_w;
  logic [60:0]        n_abs;
  logic [44:0]        b4_abs;

  assign b6_w   = a_x1 + q_p - 29'(bsc_pkg::B6Offset);
  assign t_rnd  = p1_t_sum + (p1_t_sum[29] ? 30'sd15 : 30'sd0);
  assign sq     = p2_b6sq[53:12];
  assign x1p    = p3_b2sq[58:11];
  assign x2b    = p3_b1sq[58:16];
  assign b3_rnd = p4_b3num + (p4_b3num[49] ? 50'sd3 : 50'sd0);
  assign x3_rnd = p4_x3bnum + (p4_x3bnum[43] ? 44'sd3 : 44'sd0);
  assign x3b    = x3_rnd[43:2];
  assign b7_w   = p6_upb3 * 17'(bsc_pkg::PressScale);
  assign case1  = (p7_b7[60:31] == '0);
  assign n_w    = case1 ? {p7_b7[59:0], 1'b0} : p7_b7;
  assign n_abs  = n_w[60] ? 61'(-n_w) : 61'(n_w);
  assign b4_abs = p7_b4[44] ? 45'(-p7_b4) : 45'(p7_b4);

  logic         dp_v;
  logic [60:0]  dp_quo;
  logic [28:0]  dp_side;
  logic signed [25:0] c_t_val;
  logic         c_err, c_case1, c_neg;

  bsc_div #(
    .NumWidth (61),
    .DenWidth (45),
    .SideWidth(29)
  ) u_div_press (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p8_v),
    .in_num   (p8_n_abs),
    .in_den   (p8_b4_abs),
    .in_side  ({p8_t_val, p8_err, p8_case1, p8_neg}),
    .out_valid(dp_v),
    .out_quo  (dp_quo),
    .out_side (dp_side)
  );

  assign {c_t_val, c_err, c_case1, c_neg} = dp_side;

  // final correction helpers
  logic signed [62:0] p_w;
  logic signed [23:0] x1s;
  logic [58:0]        y_w;
  logic signed [40:0] corr;
  logic signed [41:0] p_out;

  assign p_w   = q1_case1 ? 63'(q1_q) : {q1_q, 1'b0};
  assign x1s   = q2_p[31:8];
  assign y_w   = q3_x1sq[46:0] * 12'(bsc_pkg::PressC1);
  assign corr  = q5_c[44:4];
  assign p_out = q5_p + corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v  <= 1'b0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p4_v  <= 1'b0;
      p5_v  <= 1'b0;
      p6_v  <= 1'b0;
      p7_v  <= 1'b0;
      p8_v  <= 1'b0;
      q1_v  <= 1'b0;
      q2_v  <= 1'b0;
      q3_v  <= 1'b0;
      q4_v  <= 1'b0;
      q5_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      s0_v  <= skid_valid || s_accept;
      s1_v  <= s0_v;
      s2_v  <= s1_v;
      p1_v  <= d_v;
      p2_v  <= p1_v;
      p3_v  <= p2_v;
      p4_v  <= p3_v;
      p5_v  <= p4_v;
      p6_v  <= p5_v;
      p7_v  <= p6_v;
      p8_v  <= p7_v;
      q1_v  <= dp_v;
      q2_v  <= q1_v;
      q3_v  <= q2_v;
      q4_v  <= q3_v;
      q5_v  <= q4_v;
      out_v <= q5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ut    <= in_item.raw_temperature;
      s0_up    <= in_item.raw_pressure;

      s1_prod  <= ut_diff * $signed({1'b0, ac5});
      s1_up    <= s0_up;

      s2_t_x1  <= t_x1_c;
      s2_x1    <= x1_c;
      s2_t_den <= t_x1_c + md;
      s2_den   <= x1_c + md;
      s2_up    <= s1_up;

      p1_t_sum <= a_t_x1 + q_t + 30'(bsc_pkg::TempRound);
      p1_b6    <= b6_w[27:0];
      p1_up    <= a_up;
      p1_err   <= a_err;

      p2_t_val <= t_rnd[29:4];
      p2_b6sq  <= p1_b6 * p1_b6;
      p2_ac2b6 <= ac2 * p1_b6;
      p2_ac3b6 <= ac3 * p1_b6;
      p2_up    <= p1_up;
      p2_err   <= p1_err;

      p3_b2sq  <= b2 * $signed({1'b0, sq});
      p3_b1sq  <= b1 * $signed({1'b0, sq});
      p3_x2a   <= p2_ac2b6[43:11];
      p3_x1c   <= p2_ac3b6[43:13];
      p3_t_val <= p2_t_val;
      p3_up    <= p2_up;
      p3_err   <= p2_err;

      p4_b3num  <= $signed({ac1, 2'b00}) + x1p + p3_x2a + 50'sd2;
      p4_x3bnum <= p3_x1c + x2b + 44'sd2;
      p4_t_val  <= p3_t_val;
      p4_up     <= p3_up;
      p4_err    <= p3_err;

      p5_b3    <= b3_rnd[49:2];
      p5_s     <= x3b + 43'(bsc_pkg::X3Offset);
      p5_t_val <= p4_t_val;
      p5_up    <= p4_up;
      p5_err   <= p4_err;

      p6_upb3  <= $signed({1'b0, p5_up}) - p5_b3;
      p6_b4p   <= $signed({1'b0, ac4}) * p5_s;
      p6_t_val <= p5_t_val;
      p6_err   <= p5_err;

      p7_b7    <= b7_w[60:0];
      p7_b4    <= p6_b4p[59:15];
      p7_t_val <= p6_t_val;
      p7_err   <= p6_err;

      p8_n_abs  <= n_abs;
      p8_b4_abs <= b4_abs;
      p8_neg    <= n_w[60] ^ p7_b4[44];
      p8_case1  <= case1;
      p8_err    <= p7_err || (p7_b4 == '0);
      p8_t_val  <= p7_t_val;

      q1_q     <= c_neg ? -$signed({1'b0, dp_quo}) : $signed({1'b0, dp_quo});
      q1_case1 <= c_case1;
      q1_t_val <= c_t_val;
      q1_err   <= c_err;

      q2_p     <= bsc_pkg::sat32(p_w);
      q2_t_val <= q1_t_val;
      q2_err   <= q1_err;

      q3_x1sq  <= x1s * x1s;
      q3_m2    <= q2_p * -15'(bsc_pkg::PressC2);
      q3_p     <= q2_p;
      q3_t_val <= q2_t_val;
      q3_err   <= q2_err;

      q4_yf    <= y_w[58:16];
      q4_x2    <= q3_m2[46:16];
      q4_p     <= q3_p;
      q4_t_val <= q3_t_val;
      q4_err   <= q3_err;

      q5_c     <= $signed({1'b0, q4_yf}) + q4_x2 + 45'(bsc_pkg::PressC3);
      q5_p     <= q4_p;
      q5_t_val <= q4_t_val;
      q5_err   <= q4_err;

      out_data.pad                <= '0;
      out_data.divide_error       <= q5_err;
      out_data.temperature_tenths <= q5_err ? 32'sd0 : 32'(q5_t_val);
      out_data.pressure_pa        <= q5_err ? 32'sd0 : bsc_pkg::sat32(63'(p_out));
    end
  end

endmodule

// ----- hw/rtl/bsc_checker.sv -----
// Port-level checks for barometric_sensor_compensation, bound to the top.
// Uses bsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  bsc_pkg::out_item_t mdata;

  assign mdata = m_tdata;

  `BSC_ASSERT_NEXT(a_reset_clears, rst, !m_tvalid && s_tready, "reset left a transfer pending")
  `BSC_ASSERT(a_out_hold, $past(m_tvalid && !m_tready && !rst), m_tvalid && $stable(m_tdata), "stalled output changed")
  `BSC_ASSERT(a_err_zero, m_tvalid && mdata.divide_error, mdata.temperature_tenths == '0 && mdata.pressure_pa == '0, "error result not zero")
  `BSC_ASSERT(a_skid_fill, $fell(s_tready), $past(m_tvalid && !m_tready), "input held off without output stall")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
